@@ sv/lsp_pkg.sv @@
// Shared constants, codes and command/status structs for the voxel layer shadow
// propagation block. No dependencies; every other file imports it.
package lsp_pkg;

	// Grid and neighbourhood sizes
	localparam int GRID_X       = 16;
	localparam int GRID_Y       = 16;
	localparam int GRID_Z       = 16;
	localparam int MAX_RADIUS   = 4;

	localparam int CELL_COUNT   = GRID_X * GRID_Y * GRID_Z;
	localparam int ADDR_W       = (CELL_COUNT > 1) ? $clog2(CELL_COUNT) : 1;
	localparam int XW           = (GRID_X > 1) ? $clog2(GRID_X) : 1;
	localparam int YW           = (GRID_Y > 1) ? $clog2(GRID_Y) : 1;
	localparam int ZW           = (GRID_Z > 1) ? $clog2(GRID_Z) : 1;
	localparam int WEIGHT_DEPTH = 2 * MAX_RADIUS * MAX_RADIUS + 1;
	localparam int WIDX_W       = $clog2(WEIGHT_DEPTH);
	localparam int RAD_W        = $clog2(MAX_RADIUS + 1);
	localparam int OFF_W        = RAD_W + 1;
	localparam int NX_W         = ((XW > OFF_W) ? XW : OFF_W) + 2;
	localparam int NZ_W         = ((ZW > OFF_W) ? ZW : OFF_W) + 2;

	// Field widths fixed by the interface
	localparam int CELL_W       = 12;
	localparam int VAL_W        = 17;
	localparam logic [VAL_W-1:0] ONE_Q16 = 17'h10000;

	// Arithmetic widths
	localparam int TERM_MAX     = (2 * MAX_RADIUS + 1) * (2 * MAX_RADIUS + 1);
	localparam int ACC_EXT      = $clog2(TERM_MAX + 1);
	localparam int P1_W         = 34;
	localparam int TERM_W       = 51;
	localparam int NUM_W        = 48 + ACC_EXT;
	localparam int DEN_W        = VAL_W + ACC_EXT;
	localparam int N_W          = NUM_W - 16;
	localparam int Q_W          = 18;
	localparam int CNT_W        = $clog2(Q_W);
	localparam int DSH_W        = DEN_W + Q_W - 1;
	localparam int CMP_W        = DEN_W + Q_W;

	// Operation codes
	localparam logic [1:0] OP_LOAD_WEIGHT = 2'd0;
	localparam logic [1:0] OP_LOAD_SHADOW = 2'd1;
	localparam logic [1:0] OP_RUN         = 2'd2;
	localparam logic [1:0] OP_READ        = 2'd3;

	// Configuration register indexes
	localparam logic [1:0] CFG_DISK_RADIUS = 2'd0;
	localparam logic [1:0] CFG_REACH_SQ    = 2'd1;
	localparam logic [1:0] CFG_SKYLIGHT    = 2'd2;
	localparam logic [1:0] CFG_AMBIENT     = 2'd3;

	// Result kinds
	localparam logic KIND_READ = 1'b0;
	localparam logic KIND_DONE = 1'b1;

	// Commands from controller to datapath
	typedef struct packed {
		logic                     load_weight;
		logic                     load_shadow;
		logic                     capture;
		logic                     clear_wr;
		logic [ADDR_W-1:0]        clr_addr;
		logic                     term_issue;
		logic [XW-1:0]            x;
		logic [YW-1:0]            y;
		logic [ZW-1:0]            z;
		logic signed [OFF_W-1:0]  dx;
		logic signed [OFF_W-1:0]  dz;
		logic                     light_wr;
		logic                     sky_sel;
		logic                     acc_clear;
		logic                     div_start;
		logic                     rd_issue;
		logic                     emit_read;
		logic                     emit_done;
	} lsp_cmd_t;

	// Status from datapath to controller
	typedef struct packed {
		logic [RAD_W-1:0] rad;
		logic             pipe_busy;
		logic             div_busy;
	} lsp_status_t;

	// Linear voxel address
	function automatic logic [ADDR_W-1:0] addr_of(input logic [XW-1:0] x,
		input logic [YW-1:0] y, input logic [ZW-1:0] z);
		addr_of = ADDR_W'((32'(x) * GRID_Y + 32'(y)) * GRID_Z + 32'(z));
	endfunction

	// Saturate a Q1.16 value to 1.0
	function automatic logic [VAL_W-1:0] sat_one(input logic [VAL_W-1:0] v);
		sat_one = (v > ONE_Q16) ? ONE_Q16 : v;
	endfunction

endpackage

@@ sv/voxel_layer_shadow_propagation.sv @@
// Top level of the voxel layer shadow propagation block: controller plus datapath.
// Depends on lsp_pkg, lsp_ctrl and lsp_datapath.
//
// After reset the block clears the shadow store with busy high.
// A word is taken when start is high and busy low. Weight and shadow loads
// give no result. A read captures its address, reads the light memory and
// registers its result word from ST_RD_OUT. A run fills the top layer, then
// for each of the 3840 lower voxels issues one disk neighbour a cycle through
// the memory read port, (2r+1)^2 neighbours with r the clamped disk radius,
// drains the multiplier pipeline, runs the 18-step serial divider and writes
// the voxel. Each result is shown for one cycle on result_valid and must be
// taken then.
module voxel_layer_shadow_propagation (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	output logic                       busy,
	input  logic [1:0]                 operation,
	input  logic [lsp_pkg::CELL_W-1:0] cell_index,
	input  logic [lsp_pkg::VAL_W-1:0]  load_value,
	input  logic                       cfg_valid,
	output logic                       cfg_ready,
	input  logic [1:0]                 cfg_index,
	input  logic [lsp_pkg::VAL_W-1:0]  cfg_data,
	output logic                       result_valid,
	output logic                       result_kind,
	output logic [lsp_pkg::VAL_W-1:0]  light_level
);
	import lsp_pkg::*;

	lsp_cmd_t    cmd;
	lsp_status_t status;
	logic        cfg_we;

	// Configuration words are always taken
	assign cfg_ready = 1'b1;
	assign cfg_we    = cfg_valid & cfg_ready;

	lsp_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.operation (operation),
		.status    (status),
		.cmd       (cmd),
		.busy      (busy)
	);

	lsp_datapath u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.status       (status),
		.cfg_valid    (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.cell_index   (cell_index),
		.load_value   (load_value),
		.result_valid (result_valid),
		.result_kind  (result_kind),
		.light_level  (light_level)
	);

endmodule

@@ sv/lsp_ctrl.sv @@
// Controller for the shadow propagation block: state machine and loop counters.
// Depends on lsp_pkg for codes, sizes and the command/status structs.
module lsp_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic [1:0]          operation,
	input  lsp_pkg::lsp_status_t status,
	output lsp_pkg::lsp_cmd_t    cmd,
	output logic                busy
);
	import lsp_pkg::*;

	typedef enum logic [9:0] {
		ST_CLEAR    = 10'b0000000001,
		ST_IDLE     = 10'b0000000010,
		ST_RD_ISSUE = 10'b0000000100,
		ST_RD_OUT   = 10'b0000001000,
		ST_TOP      = 10'b0000010000,
		ST_TERM     = 10'b0000100000,
		ST_DRAIN    = 10'b0001000000,
		ST_DIV      = 10'b0010000000,
		ST_WRITE    = 10'b0100000000,
		ST_DONE     = 10'b1000000000
	} state_t;

	state_t                  state_q, state_d;
	logic [ADDR_W-1:0]       clr_q, clr_d;
	logic [XW-1:0]           x_q, x_d;
	logic [YW-1:0]           y_q, y_d;
	logic [ZW-1:0]           z_q, z_d;
	logic signed [OFF_W-1:0] dx_q, dx_d, dz_q, dz_d;
	logic signed [OFF_W-1:0] rad_s;
	logic                    last_x, last_z;

	assign rad_s  = $signed({1'b0, status.rad});
	assign last_x = (x_q == XW'(GRID_X - 1));
	assign last_z = (z_q == ZW'(GRID_Z - 1));
	assign busy   = (state_q != ST_IDLE);

	// Next state, counters and commands
	always_comb begin
		state_d = state_q;
		clr_d   = clr_q;
		x_d     = x_q;
		y_d     = y_q;
		z_d     = z_q;
		dx_d    = dx_q;
		dz_d    = dz_q;
		cmd     = '0;
		cmd.clr_addr = clr_q;
		cmd.x   = x_q;
		cmd.y   = y_q;
		cmd.z   = z_q;
		cmd.dx  = dx_q;
		cmd.dz  = dz_q;
		case (state_q)
			ST_CLEAR: begin
				cmd.clear_wr = 1'b1;
				clr_d = clr_q + 1'b1;
				if (clr_q == ADDR_W'(CELL_COUNT - 1)) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (start) begin
					case (operation)
						OP_LOAD_WEIGHT: cmd.load_weight = 1'b1;
						OP_LOAD_SHADOW: cmd.load_shadow = 1'b1;
						OP_RUN: begin
							x_d = '0;
							z_d = '0;
							y_d = YW'(GRID_Y - 1);
							state_d = ST_TOP;
						end
						OP_READ: begin
							cmd.capture = 1'b1;
							state_d = ST_RD_ISSUE;
						end
						default: state_d = ST_IDLE;
					endcase
				end
			end
			ST_RD_ISSUE: begin
				cmd.rd_issue = 1'b1;
				state_d = ST_RD_OUT;
			end
			ST_RD_OUT: begin
				cmd.emit_read = 1'b1;
				state_d = ST_IDLE;
			end
			ST_TOP: begin
				// fill the top layer with skylight
				cmd.light_wr  = 1'b1;
				cmd.sky_sel   = 1'b1;
				cmd.acc_clear = 1'b1;
				if (last_z) begin
					z_d = '0;
					if (last_x) begin
						x_d = '0;
						y_d = YW'(GRID_Y - 2);
						dx_d = -rad_s;
						dz_d = -rad_s;
						state_d = ST_TERM;
					end else begin
						x_d = x_q + 1'b1;
					end
				end else begin
					z_d = z_q + 1'b1;
				end
			end
			ST_TERM: begin
				// issue one neighbour a cycle over the disk
				cmd.term_issue = 1'b1;
				if (dz_q == rad_s) begin
					dz_d = -rad_s;
					if (dx_q == rad_s) begin
						state_d = ST_DRAIN;
					end else begin
						dx_d = dx_q + 1'b1;
					end
				end else begin
					dz_d = dz_q + 1'b1;
				end
			end
			ST_DRAIN: begin
				if (!status.pipe_busy) begin
					cmd.div_start = 1'b1;
					state_d = ST_DIV;
				end
			end
			ST_DIV: begin
				if (!status.div_busy) begin
					state_d = ST_WRITE;
				end
			end
			ST_WRITE: begin
				// store the voxel and advance z, then x, then down a layer
				cmd.light_wr  = 1'b1;
				cmd.acc_clear = 1'b1;
				dx_d = -rad_s;
				dz_d = -rad_s;
				state_d = ST_TERM;
				if (last_z) begin
					z_d = '0;
					if (last_x) begin
						x_d = '0;
						if (y_q == '0) begin
							state_d = ST_DONE;
						end else begin
							y_d = y_q - 1'b1;
						end
					end else begin
						x_d = x_q + 1'b1;
					end
				end else begin
					z_d = z_q + 1'b1;
				end
			end
			ST_DONE: begin
				cmd.emit_done = 1'b1;
				state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// State and counter registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			clr_q   <= '0;
			x_q     <= '0;
			y_q     <= '0;
			z_q     <= '0;
			dx_q    <= '0;
			dz_q    <= '0;
		end else begin
			state_q <= state_d;
			clr_q   <= clr_d;
			x_q     <= x_d;
			y_q     <= y_d;
			z_q     <= z_d;
			dx_q    <= dx_d;
			dz_q    <= dz_d;
		end
	end

endmodule

@@ sv/lsp_datapath.sv @@
// Datapath: configuration registers, voxel and weight memories, term pipeline,
// accumulators and serial divider. Depends on lsp_pkg.
module lsp_datapath (
	input  logic                      clk,
	input  logic                      arst_n,
	input  lsp_pkg::lsp_cmd_t          cmd,
	output lsp_pkg::lsp_status_t       status,
	input  logic                      cfg_valid,
	input  logic [1:0]                cfg_index,
	input  logic [lsp_pkg::VAL_W-1:0] cfg_data,
	input  logic [lsp_pkg::CELL_W-1:0] cell_index,
	input  logic [lsp_pkg::VAL_W-1:0] load_value,
	output logic                      result_valid,
	output logic                      result_kind,
	output logic [lsp_pkg::VAL_W-1:0] light_level
);
	import lsp_pkg::*;

	// Configuration
	logic [2:0]       disk_radius_q;
	logic [5:0]       reach_q;
	logic [VAL_W-1:0] sky_q, amb_q;

	// Memories
	logic [VAL_W-1:0] light_mem  [CELL_COUNT];
	logic [VAL_W-1:0] shadow_mem [CELL_COUNT];
	logic [VAL_W-1:0] weight_mem [WEIGHT_DEPTH];
	logic [WEIGHT_DEPTH-1:0] wvalid_q;
	logic             lit_q;

	// Read item
	logic [ADDR_W-1:0] rd_addr_q;
	logic              rd_inr_q;

	// Term pipeline
	logic signed [NX_W-1:0] nx;
	logic signed [NZ_W-1:0] nz;
	logic                   in_grid;
	logic signed [2*OFF_W-1:0] dxx, dzz;
	logic [2*OFF_W:0]       r2;
	logic [WIDX_W-1:0]      widx;
	logic                   use_term;
	logic [ADDR_W-1:0]      nb_addr, raddr, waddr, saddr;
	logic [VAL_W-1:0]       light_rd_s1, shadow_rd_s1, w_rd_s1, w_eff;
	logic                   w_ok_s1, v_s1, off_s1;
	logic [P1_W-1:0]        p1_s2;
	logic [VAL_W-1:0]       ns_s2, w_s2;
	logic                   v_s2, off_s2;
	logic [TERM_W-1:0]      prod;
	logic [TERM_W-1:0]      term_s3;
	logic                   v_s3;
	logic [NUM_W-1:0]       num_q;
	logic [DEN_W-1:0]       den_q;

	// Divider
	logic [N_W-1:0]   rem_q;
	logic [DSH_W-1:0] dsh_q;
	logic [Q_W-1:0]   q_q;
	logic [CNT_W-1:0] cnt_q;
	logic             div_run_q, ovf_q, ge;

	// Voxel result
	logic [VAL_W-1:0] cap, qv, vox_val, light_wdata;
	logic [YW-1:0]    y_up;

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			disk_radius_q <= 3'd1;
			reach_q       <= 6'd2;
			sky_q         <= ONE_Q16;
			amb_q         <= '0;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_DISK_RADIUS: disk_radius_q <= cfg_data[2:0];
				CFG_REACH_SQ:    reach_q       <= cfg_data[5:0];
				CFG_SKYLIGHT:    sky_q         <= sat_one(cfg_data);
				CFG_AMBIENT:     amb_q         <= sat_one(cfg_data);
				default:         amb_q         <= amb_q;
			endcase
		end
	end

	assign status.rad = (32'(disk_radius_q) > MAX_RADIUS) ? RAD_W'(MAX_RADIUS)
		: RAD_W'(disk_radius_q);
	assign status.pipe_busy = v_s1 | v_s2 | v_s3;
	assign status.div_busy  = div_run_q;

	// Neighbour geometry
	assign nx = $signed({{(NX_W-XW){1'b0}}, cmd.x}) + NX_W'(cmd.dx);
	assign nz = $signed({{(NZ_W-ZW){1'b0}}, cmd.z}) + NZ_W'(cmd.dz);
	assign in_grid = (nx >= 0) && (nx < GRID_X) && (nz >= 0) && (nz < GRID_Z);
	assign dxx = cmd.dx * cmd.dx;
	assign dzz = cmd.dz * cmd.dz;
	assign r2  = {1'b0, dxx} + {1'b0, dzz};
	assign widx = r2[WIDX_W-1:0];
	assign use_term = (r2 <= (2*OFF_W+1)'(reach_q)) && (r2 < (2*OFF_W+1)'(WEIGHT_DEPTH));
	assign y_up = cmd.y + 1'b1;
	assign nb_addr = addr_of(nx[XW-1:0], y_up, nz[ZW-1:0]);
	assign raddr = cmd.rd_issue ? rd_addr_q : nb_addr;
	assign waddr = addr_of(cmd.x, cmd.y, cmd.z);
	assign saddr = cmd.clear_wr ? cmd.clr_addr : cell_index[ADDR_W-1:0];

	// Voxel result: clamp the quotient, then add ambient
	assign cap = ONE_Q16 - amb_q;
	assign qv  = (ovf_q || (q_q > Q_W'(cap))) ? cap : q_q[VAL_W-1:0];
	assign vox_val = (den_q == '0) ? amb_q : qv + amb_q;
	assign light_wdata = cmd.sky_sel ? sky_q : vox_val;

	// Light memory: one write, one registered read
	always_ff @(posedge clk) begin
		if (cmd.light_wr) begin
			light_mem[waddr] <= light_wdata;
		end
		light_rd_s1 <= light_mem[raddr];
	end

	// Shadow memory: loads and the clearing pass
	always_ff @(posedge clk) begin
		if (cmd.clear_wr) begin
			shadow_mem[saddr] <= '0;
		end else if (cmd.load_shadow && (32'(cell_index) < CELL_COUNT)) begin
			shadow_mem[saddr] <= sat_one(load_value);
		end
		shadow_rd_s1 <= shadow_mem[raddr];
	end

	// Weight memory
	always_ff @(posedge clk) begin
		if (cmd.load_weight && (32'(cell_index) < WEIGHT_DEPTH)) begin
			weight_mem[cell_index[WIDX_W-1:0]] <= sat_one(load_value);
		end
		w_rd_s1 <= weight_mem[widx];
		w_ok_s1 <= wvalid_q[widx];
	end

	// Valid bits and read item capture
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wvalid_q <= '0;
			lit_q    <= 1'b0;
		end else begin
			if (cmd.load_weight && (32'(cell_index) < WEIGHT_DEPTH)) begin
				wvalid_q[cell_index[WIDX_W-1:0]] <= 1'b1;
			end
			if (cmd.light_wr && cmd.sky_sel) begin
				lit_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			rd_addr_q <= cell_index[ADDR_W-1:0];
			rd_inr_q  <= (32'(cell_index) < CELL_COUNT);
		end
	end

	// Term pipeline valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			v_s1 <= cmd.term_issue && use_term;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	assign w_eff = w_ok_s1 ? w_rd_s1 : '0;
	assign prod  = p1_s2 * ns_s2;

	// Term pipeline payload: light*weight, then times transmittance; the weight alone off the grid
	always_ff @(posedge clk) begin
		off_s1  <= !in_grid;
		p1_s2   <= light_rd_s1 * w_eff;
		ns_s2   <= ONE_Q16 - shadow_rd_s1;
		w_s2    <= w_eff;
		off_s2  <= off_s1;
		term_s3 <= off_s2 ? TERM_W'({w_s2, 32'b0}) : prod;
	end

	// Accumulate numerator and weight total
	always_ff @(posedge clk) begin
		if (cmd.acc_clear) begin
			num_q <= '0;
			den_q <= '0;
		end else begin
			if (v_s2) begin
				den_q <= den_q + DEN_W'(w_s2);
			end
			if (v_s3) begin
				num_q <= num_q + NUM_W'(term_s3);
			end
		end
	end

	// Restoring divider, one quotient bit a cycle
	assign ge = (CMP_W'(rem_q) >= CMP_W'(dsh_q));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			div_run_q <= 1'b0;
			cnt_q     <= '0;
		end else if (cmd.div_start) begin
			div_run_q <= 1'b1;
			cnt_q     <= CNT_W'(Q_W - 1);
		end else if (div_run_q) begin
			if (cnt_q == '0) begin
				div_run_q <= 1'b0;
			end else begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.div_start) begin
			rem_q <= num_q[NUM_W-1:16];
			dsh_q <= {den_q, {(Q_W-1){1'b0}}};
			ovf_q <= (CMP_W'(num_q[NUM_W-1:16]) >= {den_q, {Q_W{1'b0}}});
			q_q   <= '0;
		end else if (div_run_q) begin
			if (ge) begin
				rem_q <= rem_q - N_W'(dsh_q);
			end
			q_q   <= {q_q[Q_W-2:0], ge};
			dsh_q <= dsh_q >> 1;
		end
	end

	// Result word register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid <= 1'b0;
		end else begin
			result_valid <= cmd.emit_read | cmd.emit_done;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit_read) begin
			result_kind <= KIND_READ;
			light_level <= (rd_inr_q && lit_q) ? light_rd_s1 : '0;
		end else if (cmd.emit_done) begin
			result_kind <= KIND_DONE;
			light_level <= '0;
		end
	end

endmodule

@@ sim/tb_voxel_layer_shadow_propagation.sv @@
// Self-checking testbench for voxel_layer_shadow_propagation: drives commands
// and register writes, predicts each result word in a class. Depends on lsp_pkg.
module tb_voxel_layer_shadow_propagation;
	import lsp_pkg::*;

	localparam int STALL_LIMIT = 2000000;

	// Shadow-propagation predictor and queue of expected result words
	class light_predictor;
		int unsigned disk_radius, reach_sq, skylight, ambient;
		int unsigned light_mem[CELL_COUNT];
		int unsigned shadow_mem[CELL_COUNT];
		int unsigned weight_mem[WEIGHT_DEPTH];
		logic        kind_q[$];
		int unsigned level_q[$];
		int          mismatches;

		function new();
			disk_radius = 1;
			reach_sq    = 2;
			skylight    = 65536;
			ambient     = 0;
			mismatches  = 0;
			foreach (light_mem[i]) begin
				light_mem[i]  = 0;
				shadow_mem[i] = 0;
			end
			foreach (weight_mem[i]) weight_mem[i] = 0;
		endfunction

		function int unsigned clip_one(int unsigned v);
			return (v > 65536) ? 65536 : v;
		endfunction

		function void write_register(logic [1:0] idx, logic [VAL_W-1:0] data);
			case (idx)
				CFG_DISK_RADIUS: disk_radius = data & 7;
				CFG_REACH_SQ:    reach_sq = data & 63;
				CFG_SKYLIGHT:    skylight = clip_one(data);
				CFG_AMBIENT:     ambient = clip_one(data);
			endcase
		endfunction

		// Weighted mean of the disk in the layer above, clamped, plus ambient
		function int unsigned voxel_level(int x, int y, int z, int rad);
			longint unsigned num, den, w, q;
			int unsigned r2, a;
			int nx, nz;
			num = 0;
			den = 0;
			for (int dx = -rad; dx <= rad; dx++) begin
				for (int dz = -rad; dz <= rad; dz++) begin
					r2 = dx * dx + dz * dz;
					if (r2 > reach_sq || r2 >= WEIGHT_DEPTH) continue;
					w = weight_mem[r2];
					den += w;
					nx = x + dx;
					nz = z + dz;
					if (nx < 0 || nx >= GRID_X || nz < 0 || nz >= GRID_Z) begin
						num += w << 32;
					end else begin
						a = (nx * GRID_Y + y + 1) * GRID_Z + nz;
						num += longint'(light_mem[a]) * w * longint'(65536 - shadow_mem[a]);
					end
				end
			end
			if (den == 0) return ambient;
			q = num / (den << 16);
			if (q > 65536 - ambient) q = 65536 - ambient;
			return int'(q) + ambient;
		endfunction

		function void propagate();
			int rad;
			rad = (disk_radius > MAX_RADIUS) ? MAX_RADIUS : disk_radius;
			for (int x = 0; x < GRID_X; x++)
				for (int z = 0; z < GRID_Z; z++)
					light_mem[(x * GRID_Y + GRID_Y - 1) * GRID_Z + z] = skylight;
			for (int y = GRID_Y - 2; y >= 0; y--)
				for (int x = 0; x < GRID_X; x++)
					for (int z = 0; z < GRID_Z; z++)
						light_mem[(x * GRID_Y + y) * GRID_Z + z] = voxel_level(x, y, z, rad);
		endfunction

		function void note_command(logic [1:0] op, logic [CELL_W-1:0] idx,
			logic [VAL_W-1:0] val);
			case (op)
				OP_LOAD_WEIGHT: if (idx < WEIGHT_DEPTH) weight_mem[idx] = clip_one(val);
				OP_LOAD_SHADOW: if (idx < CELL_COUNT) shadow_mem[idx] = clip_one(val);
				OP_RUN: begin
					propagate();
					kind_q.push_back(KIND_DONE);
					level_q.push_back(0);
				end
				OP_READ: begin
					kind_q.push_back(KIND_READ);
					level_q.push_back((idx < CELL_COUNT) ? light_mem[idx] : 0);
				end
			endcase
		endfunction

		function void check_word(logic kind, logic [VAL_W-1:0] level);
			logic        ek;
			int unsigned el;
			if (kind_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result word: kind %0d level %0d", kind, level);
				return;
			end
			ek = kind_q.pop_front();
			el = level_q.pop_front();
			if (kind !== ek || level !== el[VAL_W-1:0]) begin
				mismatches++;
				if (mismatches <= 10)
					$display("result mismatch: expected kind %0d level %0d, got kind %0d level %0d",
						ek, el, kind, level);
			end
		endfunction
	endclass

	logic             clk, arst_n, start, busy;
	logic [1:0]       operation;
	logic [CELL_W-1:0] cell_index;
	logic [VAL_W-1:0] load_value;
	logic             cfg_valid, cfg_ready;
	logic [1:0]       cfg_index;
	logic [VAL_W-1:0] cfg_data;
	logic             result_valid, result_kind;
	logic [VAL_W-1:0] light_level;

	light_predictor model = new();
	bit  idle_enable = 1;
	int  stall_count = 0;

	voxel_layer_shadow_propagation i_dut (.*);

	// Clock
	always begin
		clk = 1'b0;
		#1;
		clk = 1'b1;
		#1;
	end

	// Observe handshakes and check result words
	always @(posedge clk) begin
		if (arst_n) begin
			if (start && !busy) model.note_command(operation, cell_index, load_value);
			if (cfg_valid && cfg_ready) model.write_register(cfg_index, cfg_data);
			if (result_valid) model.check_word(result_kind, light_level);
			if ((start && !busy) || (cfg_valid && cfg_ready) || result_valid)
				stall_count <= 0;
			else
				stall_count <= stall_count + 1;
			if (stall_count >= STALL_LIMIT) begin
				$display("voxel_layer_shadow_propagation verification failed");
				$finish;
			end
		end
	end

	// Maybe idle first, then hold the command word until it is taken
	task automatic send_word(logic [1:0] op, logic [CELL_W-1:0] idx, logic [VAL_W-1:0] val);
		if (idle_enable && $urandom_range(0, 99) < 20) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
		start      <= 1'b1;
		operation  <= op;
		cell_index <= idx;
		load_value <= val;
		do @(posedge clk); while (busy);
	endtask

	// Drop start and wait until every expected word has arrived and the block is idle
	task automatic drain();
		start <= 1'b0;
		@(posedge clk);
		while (model.kind_q.size() != 0) @(posedge clk);
		repeat (10) @(posedge clk);
		while (busy) @(posedge clk);
	endtask

	// Offer one register word, then drop valid
	task automatic write_reg(logic [1:0] idx, logic [VAL_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic set_all(int unsigned rad, int unsigned rsq, int unsigned sky, int unsigned amb);
		write_reg(CFG_DISK_RADIUS, VAL_W'(rad));
		write_reg(CFG_REACH_SQ, VAL_W'(rsq));
		write_reg(CFG_SKYLIGHT, VAL_W'(sky));
		write_reg(CFG_AMBIENT, VAL_W'(amb));
	endtask

	// Random phase: loads and reads with one run at a random place
	task automatic random_phase(int count);
		int run_at, pick;
		run_at = $urandom_range(count / 3, count - 10);
		for (int i = 0; i < count; i++) begin
			if (i == run_at) begin
				send_word(OP_RUN, CELL_W'($urandom_range(0, 4095)),
					VAL_W'($urandom_range(0, 131071)));
				continue;
			end
			pick = $urandom_range(0, 99);
			if (pick < 40)
				send_word(OP_LOAD_SHADOW, CELL_W'($urandom_range(0, 4095)),
					VAL_W'($urandom_range(0, 131071)));
			else if (pick < 65)
				send_word(OP_LOAD_WEIGHT, CELL_W'($urandom_range(0, 40)),
					VAL_W'($urandom_range(0, 131071)));
			else
				send_word(OP_READ, CELL_W'($urandom_range(0, 4095)),
					VAL_W'($urandom_range(0, 131071)));
		end
	endtask

	initial begin
		arst_n     = 1'b0;
		start      = 1'b0;
		operation  = OP_READ;
		cell_index = '0;
		load_value = '0;
		cfg_valid  = 1'b0;
		cfg_index  = CFG_DISK_RADIUS;
		cfg_data   = '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// Directed: default registers, saturating and ignored loads, reads and a run
		idle_enable = 0;
		send_word(OP_READ, 12'd0, '0);
		send_word(OP_LOAD_WEIGHT, 12'd0, 17'h1FFFF);
		send_word(OP_LOAD_WEIGHT, 12'd1, 17'd30000);
		send_word(OP_LOAD_WEIGHT, 12'd2, 17'd0);
		send_word(OP_LOAD_WEIGHT, 12'd33, 17'd5000);
		send_word(OP_LOAD_WEIGHT, 12'd4095, 17'd5000);
		send_word(OP_LOAD_SHADOW, 12'd4095, 17'h1FFFF);
		send_word(OP_LOAD_SHADOW, 12'd0, 17'd65536);
		send_word(OP_LOAD_SHADOW, 12'h8F7, 17'd12345);
		send_word(OP_LOAD_SHADOW, 12'h7F8, 17'd0);
		send_word(OP_RUN, 12'hFFF, 17'h1FFFF);
		send_word(OP_READ, 12'hFFF, '0);
		send_word(OP_READ, 12'h0F0, 17'h1FFFF);
		send_word(OP_READ, 12'h000, '0);
		send_word(OP_READ, 12'h8E7, '0);
		send_word(OP_READ, 12'hAAA, '0);
		send_word(OP_READ, 12'h555, '0);
		drain();

		// Zero weight total: every lower voxel becomes ambient; oversized sky
		set_all(0, 0, 17'h1FFFF, 17'd30000);
		send_word(OP_LOAD_WEIGHT, 12'd0, 17'd0);
		send_word(OP_RUN, 12'd0, 17'd0);
		send_word(OP_READ, 12'h0F0, '0);
		send_word(OP_READ, 12'h3A5, '0);
		drain();

		// Widest disk, full reach, oversized ambient then zero ambient
		write_reg(CFG_AMBIENT, 17'h1FFFF);
		set_all(7, 63, 17'd40000, 17'd0);
		for (int r = 0; r < WEIGHT_DEPTH; r++)
			send_word(OP_LOAD_WEIGHT, CELL_W'(r), VAL_W'($urandom_range(0, 65536)));
		send_word(OP_RUN, 12'd7, 17'd7);
		send_word(OP_READ, 12'h005, '0);
		send_word(OP_READ, 12'hF00, '0);
		drain();

		// Random phases at small radii
		idle_enable = 1;
		set_all($urandom_range(0, 1), $urandom_range(0, 63), $urandom_range(0, 131071),
			$urandom_range(0, 65536));
		random_phase(25);
		drain();
		set_all(0, $urandom_range(0, 63), $urandom_range(0, 131071), 17'd65536);
		random_phase(25);

		drain();
		repeat (20) @(posedge clk);
		if (model.mismatches == 0 && model.kind_q.size() == 0)
			$display("voxel_layer_shadow_propagation verification clean");
		else
			$display("voxel_layer_shadow_propagation verification failed");
		$finish;
	end

endmodule

@@ filelist.f @@
sv/lsp_pkg.sv
sv/lsp_ctrl.sv
sv/lsp_datapath.sv
sv/voxel_layer_shadow_propagation.sv
sim/tb_voxel_layer_shadow_propagation.sv
